/* src/kwg_pkg.sv */
// Shared types, constants and command/status bundles for the Kaiser window generator.
// Used by the controller, the datapath, the divider and the top level.
`default_nettype none

package kwg_pkg;

    // Field and register widths
    localparam int LEN_W     = 13;
    localparam int BETA_W    = 16;
    localparam int IDX_W     = 12;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Window limits and series length
    localparam int MAX_LENGTH   = 4096;
    localparam int SERIES_TERMS = 50;
    localparam int K_W          = $clog2(SERIES_TERMS);

    // Datapath widths
    localparam int Q_W    = 24;           // 4n(m-n) and (L-1)^2
    localparam int F_W    = 33;           // Q0.32 argument, up to 1.0
    localparam int RES_W  = 34;           // square root working value
    localparam int ROOT_W = 17;           // Q0.16 root, up to 1.0
    localparam int X_W    = 28;           // Q4.24 Bessel argument
    localparam int HALF_W = 27;
    localparam int SUM_W  = 48;           // Q24.24 sums and terms
    localparam int MA_W   = 48;           // multiplier A operand
    localparam int MH_W   = 24;           // multiplier A half
    localparam int MB_W   = 32;           // multiplier B operand
    localparam int MP_W   = MH_W + MB_W;  // partial product
    localparam int MR_W   = MP_W + 1;     // recombined product
    localparam int DIV_W  = 60;           // dividend / quotient
    localparam int DVS_W  = 48;           // divisor / remainder
    localparam int DCNT_W = 6;

    // Divide lengths for each use, dividends are left aligned in DIV_W bits
    localparam int DIVF_BITS = 56;
    localparam int DIVT_BITS = HALF_W;
    localparam int DIVC_BITS = DIV_W;

    localparam logic [SUM_W-1:0]  Q24_ONE  = SUM_W'(1) << 24;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(32768);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_SHAPE    = CFG_IDX_W'(1);
    localparam logic [LEN_W-1:0]     LEN_RESET         = LEN_W'(64);
    localparam logic [BETA_W-1:0]    BETA_RESET        = BETA_W'(20480);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SET_Q,
        ST_SET_D,
        ST_DIVF_GO,
        ST_DIVF_WAIT,
        ST_SQRT,
        ST_MULX_LO,
        ST_MULX_HI,
        ST_MULX_WB,
        ST_BES_INIT,
        ST_BES_DIV_GO,
        ST_BES_DIV_WAIT,
        ST_BES_TT_LO,
        ST_BES_TT_HI,
        ST_BES_TT_WB,
        ST_BES_TM_LO,
        ST_BES_TM_HI,
        ST_BES_TM_WB,
        ST_BES_ACC,
        ST_DIVC_GO,
        ST_DIVC_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DSEL_F,   // (4n(m-n) << 32) / (m*m)
        DSEL_T,   // (x/2) / k
        DSEL_C    // final ratio
    } div_sel_t;

    typedef enum logic [1:0] {
        MSEL_X,   // beta * root
        MSEL_TT,  // t * t
        MSEL_TM   // term * t2
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        logic     latch_flags;
        logic     set_q;
        logic     set_d;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     mul_lo;
        logic     mul_hi;
        mul_sel_t mul_sel;
        logic     x_wb;
        logic     t2_wb;
        logic     term_wb;
        logic     bes_init;
        logic     bes_arg;    // 0: sample argument, 1: beta
        logic     bes_acc;
        logic     store_num;
        logic     store_den;
        logic     load_out;
    } kwg_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_done;
        logic oor;
        logic single;
        logic bes_done;
        logic out_stall;
    } kwg_status_t;

endpackage

`default_nettype wire

/* src/kaiser_window_generator.sv */
// Kaiser window generator: one coefficient I0(beta*sqrt(1-r^2))/I0(beta) per sample index.
// Top level; instantiates kwg_controller and kwg_datapath, uses kwg_pkg.
//
// Usage:
//   Write window_length (index 0) and beta_shape (index 1, Q4.12) through the
//   cfg_wr_en/cfg_index/cfg_data port while no item is in flight. Writes to
//   other indexes are dropped. Reset sets length 64 and beta 5.0.
//   Present a sample index on s_sample_index with s_valid; it transfers when
//   s_ready is high. One result transfers on m_valid/m_ready: the Q1.15
//   coefficient and the out_of_range flag.
//   Work: an index outside the window, or a window of length one, skips the
//   arithmetic. Otherwise the work is a 56-bit divide, 17 square-root steps
//   and the final 60-bit divide, plus the work for each series term, for each
//   of the two Bessel sums of up to 49 terms. The divider is shared and gives
//   one quotient bit per cycle.
//   One item is worked on at a time. The result sits in an output register,
//   so the next index is taken while it waits; when the receiver stalls, the
//   next result is held back until the register frees.
//   After reset the block is idle and ready at once.
`default_nettype none

module kaiser_window_generator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [kwg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kwg_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [kwg_pkg::IDX_W-1:0]      s_sample_index,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [kwg_pkg::COEF_W-1:0]          m_coefficient,
    output logic                                m_out_of_range
);
    import kwg_pkg::*;

    kwg_cmd_t    cmd;
    kwg_status_t status;

    // Sequence the work
    kwg_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and storage
    kwg_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_sample_index (s_sample_index),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_coefficient  (m_coefficient),
        .m_out_of_range (m_out_of_range)
    );

endmodule

`default_nettype wire

/* src/kwg_divider.sv */
// Restoring divider, one quotient bit per cycle, for the Kaiser window generator.
// Dividend arrives left aligned; nbits sets the iteration count. Depends on kwg_pkg.
`default_nettype none

module kwg_divider (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [kwg_pkg::DIV_W-1:0]   dividend,
    input  wire logic [kwg_pkg::DVS_W-1:0]   divisor,
    input  wire logic [kwg_pkg::DCNT_W-1:0]  nbits,
    output logic                             busy,
    output logic [kwg_pkg::DIV_W-1:0]        quotient
);
    import kwg_pkg::*;

    logic                 busy_reg,  busy_next;
    logic [DCNT_W-1:0]    cnt_reg,   cnt_next;
    logic [DIV_W-1:0]     quo_reg,   quo_next;
    logic [DVS_W-1:0]     rem_reg,   rem_next;
    logic [DVS_W-1:0]     dvs_reg,   dvs_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;

    // One trial subtraction per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* src/kwg_datapath.sv */
// Datapath of the Kaiser window generator: configuration, argument, square root,
// shared multiplier, Bessel series registers and output register. Uses kwg_pkg, kwg_divider.
`default_nettype none

module kwg_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [kwg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kwg_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic [kwg_pkg::IDX_W-1:0]      s_sample_index,
    input  wire logic                           m_ready,
    input  wire kwg_pkg::kwg_cmd_t              cmd,
    output kwg_pkg::kwg_status_t                status,
    output logic                                m_valid,
    output logic [kwg_pkg::COEF_W-1:0]          m_coefficient,
    output logic                                m_out_of_range
);
    import kwg_pkg::*;

    // Configuration
    logic [LEN_W-1:0]  window_length_reg;
    logic [BETA_W-1:0] beta_shape_reg;

    // Item registers
    logic [IDX_W-1:0]  idx_reg;
    logic              oor_reg;
    logic              single_reg;
    logic [Q_W-1:0]    q_reg;
    logic [Q_W-1:0]    d_reg;

    // Square root
    logic [F_W-1:0]    sq_v_reg;
    logic [RES_W-1:0]  sq_res_reg;
    logic [F_W-1:0]    sq_bit_reg;
    logic [RES_W:0]    sq_trial;

    // Multiplier
    logic [MA_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [MH_W-1:0]   mul_half;
    logic [MP_W-1:0]   mul_prod;
    logic [MP_W-1:0]   mul_p0_reg;
    logic [MP_W-1:0]   mul_p1_reg;
    logic [MR_W-1:0]   mul_res;

    // Series
    logic [X_W-1:0]    x_reg;
    logic [X_W-1:0]    xb;
    logic [HALF_W-1:0] half_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  term_reg;
    logic [MB_W-1:0]   t2_reg;
    logic [K_W-1:0]    k_reg;
    logic [SUM_W-1:0]  sum_add;
    logic [SUM_W-1:0]  num_reg;
    logic [SUM_W-1:0]  den_reg;

    // Divider hookup
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DCNT_W-1:0] div_nbits;
    logic              div_busy;
    logic [DIV_W-1:0]  div_quot;

    // Misc combinational
    logic [LEN_W-1:0]   len_eff;
    logic [IDX_W-1:0]   m_last;
    logic [IDX_W-1:0]   sm_a;
    logic [IDX_W-1:0]   sm_b;
    logic [2*IDX_W-1:0] sm_prod;
    logic [COEF_W-1:0]  coef_calc;
    logic [COEF_W-1:0]  coef_sel;

    logic              m_valid_reg;
    logic [COEF_W-1:0] m_coef_reg;
    logic              m_oor_reg;

    // Write configuration registers, ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= LEN_RESET;
            beta_shape_reg    <= BETA_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_WINDOW_LENGTH) begin
                window_length_reg <= cfg_data[LEN_W-1:0];
            end else if (cfg_index == REG_BETA_SHAPE) begin
                beta_shape_reg <= cfg_data[BETA_W-1:0];
            end
        end
    end

    // Clamp length and derive range flags
    always_comb begin
        len_eff = (window_length_reg > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                           : window_length_reg;
        m_last  = IDX_W'(len_eff - LEN_W'(1));
        sm_a    = cmd.set_q ? idx_reg : m_last;
        sm_b    = cmd.set_q ? (m_last - idx_reg) : m_last;
        sm_prod = sm_a * sm_b;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            idx_reg <= s_sample_index;
        end
        if (cmd.latch_flags) begin
            oor_reg    <= (len_eff == '0) || ({1'b0, idx_reg} >= len_eff);
            single_reg <= (len_eff == LEN_W'(1));
        end
        if (cmd.set_q) begin
            q_reg <= {sm_prod[Q_W-3:0], 2'b00};
        end
        if (cmd.set_d) begin
            d_reg <= sm_prod;
        end
    end

    // Select divider operands, dividends left aligned
    always_comb begin
        unique case (cmd.div_sel)
            DSEL_F: begin
                div_dividend = {q_reg, (DIV_W-Q_W)'(0)};
                div_divisor  = DVS_W'(d_reg);
                div_nbits    = DCNT_W'(DIVF_BITS);
            end
            DSEL_T: begin
                div_dividend = {half_reg, (DIV_W-HALF_W)'(0)};
                div_divisor  = DVS_W'(k_reg);
                div_nbits    = DCNT_W'(DIVT_BITS);
            end
            DSEL_C: begin
                div_dividend = DIV_W'({num_reg, 15'b0}) + DIV_W'(den_reg >> 1);
                div_divisor  = den_reg;
                div_nbits    = DCNT_W'(DIVC_BITS);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
                div_nbits    = '0;
            end
        endcase
    end

    kwg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .nbits    (div_nbits),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Square root, one result bit per cycle
    assign sq_trial = {1'b0, sq_res_reg} + (RES_W+1)'(sq_bit_reg);

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            sq_v_reg   <= div_quot[F_W-1:0];
            sq_res_reg <= '0;
            sq_bit_reg <= F_W'(1) << 32;
        end else if (cmd.sqrt_step) begin
            if ((RES_W+1)'(sq_v_reg) >= sq_trial) begin
                sq_v_reg   <= F_W'((RES_W+1)'(sq_v_reg) - sq_trial);
                sq_res_reg <= (sq_res_reg >> 1) + RES_W'(sq_bit_reg);
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    // Multiply (a*b) >> 24 in two halves of A
    always_comb begin
        unique case (cmd.mul_sel)
            MSEL_X: begin
                mul_a = MA_W'({beta_shape_reg, 20'b0});
                mul_b = MB_W'(sq_res_reg[ROOT_W-1:0]);
            end
            MSEL_TT: begin
                mul_a = MA_W'(div_quot[HALF_W-1:0]);
                mul_b = MB_W'(div_quot[HALF_W-1:0]);
            end
            MSEL_TM: begin
                mul_a = term_reg;
                mul_b = t2_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_half = cmd.mul_hi ? mul_a[MA_W-1:MH_W] : mul_a[MH_W-1:0];
        mul_prod = mul_half * mul_b;
        mul_res  = MR_W'(mul_p1_reg) + MR_W'(mul_p0_reg >> 24);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            mul_p0_reg <= mul_prod;
        end
        if (cmd.mul_hi) begin
            mul_p1_reg <= mul_prod;
        end
    end

    // Bessel series registers
    assign xb      = X_W'({beta_shape_reg, 12'b0});
    assign sum_add = sum_reg + term_reg;

    always_ff @(posedge aclk) begin
        if (cmd.x_wb) begin
            x_reg <= mul_res[X_W-1:0];
        end
        if (cmd.t2_wb) begin
            t2_reg <= mul_res[MB_W-1:0];
        end
        if (cmd.term_wb) begin
            term_reg <= mul_res[SUM_W-1:0];
        end else if (cmd.bes_init) begin
            term_reg <= Q24_ONE;
        end
        if (cmd.bes_init) begin
            half_reg <= HALF_W'((cmd.bes_arg ? xb : x_reg) >> 1);
            sum_reg  <= Q24_ONE;
            k_reg    <= K_W'(1);
        end else if (cmd.bes_acc) begin
            sum_reg <= sum_add;
            k_reg   <= k_reg + K_W'(1);
        end
        if (cmd.store_num) begin
            num_reg <= sum_add;
        end
        if (cmd.store_den) begin
            den_reg <= sum_add;
        end
    end

    // Round result already in quotient; clamp to 1.0
    always_comb begin
        coef_calc = (div_quot > DIV_W'(COEF_ONE)) ? COEF_ONE : div_quot[COEF_W-1:0];
        if (oor_reg) begin
            coef_sel = '0;
        end else if (single_reg) begin
            coef_sel = COEF_ONE;
        end else begin
            coef_sel = coef_calc;
        end
    end

    // Output register, holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_coef_reg <= coef_sel;
            m_oor_reg  <= oor_reg;
        end
    end

    always_comb begin
        status.div_busy  = div_busy;
        status.sqrt_done = (sq_bit_reg == '0);
        status.oor       = (len_eff == '0) || ({1'b0, idx_reg} >= len_eff);
        status.single    = (len_eff == LEN_W'(1));
        status.bes_done  = (term_reg == '0) || (k_reg == K_W'(SERIES_TERMS - 1));
        status.out_stall = m_valid_reg && !m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_coefficient  = m_coef_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

`default_nettype wire

/* src/kwg_controller.sv */
// Sequencer for the Kaiser window generator: steps the datapath through argument,
// square root, two Bessel series and the final ratio. Depends on kwg_pkg.
`default_nettype none

module kwg_controller (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire kwg_pkg::kwg_status_t  status,
    output kwg_pkg::kwg_cmd_t          cmd
);
    import kwg_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        pass_reg,  pass_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            ST_IDLE:         if (s_valid) state_next = ST_CHECK;
            ST_CHECK: begin
                pass_next = 1'b0;
                if (status.oor || status.single) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SET_Q;
                end
            end
            ST_SET_Q:        state_next = ST_SET_D;
            ST_SET_D:        state_next = ST_DIVF_GO;
            ST_DIVF_GO:      state_next = ST_DIVF_WAIT;
            ST_DIVF_WAIT:    if (!status.div_busy) state_next = ST_SQRT;
            ST_SQRT:         if (status.sqrt_done) state_next = ST_MULX_LO;
            ST_MULX_LO:      state_next = ST_MULX_HI;
            ST_MULX_HI:      state_next = ST_MULX_WB;
            ST_MULX_WB:      state_next = ST_BES_INIT;
            ST_BES_INIT:     state_next = ST_BES_DIV_GO;
            ST_BES_DIV_GO:   state_next = ST_BES_DIV_WAIT;
            ST_BES_DIV_WAIT: if (!status.div_busy) state_next = ST_BES_TT_LO;
            ST_BES_TT_LO:    state_next = ST_BES_TT_HI;
            ST_BES_TT_HI:    state_next = ST_BES_TT_WB;
            ST_BES_TT_WB:    state_next = ST_BES_TM_LO;
            ST_BES_TM_LO:    state_next = ST_BES_TM_HI;
            ST_BES_TM_HI:    state_next = ST_BES_TM_WB;
            ST_BES_TM_WB:    state_next = ST_BES_ACC;
            ST_BES_ACC: begin
                if (!status.bes_done) begin
                    state_next = ST_BES_DIV_GO;
                end else if (!pass_reg) begin
                    pass_next  = 1'b1;
                    state_next = ST_BES_INIT;
                end else begin
                    state_next = ST_DIVC_GO;
                end
            end
            ST_DIVC_GO:      state_next = ST_DIVC_WAIT;
            ST_DIVC_WAIT:    if (!status.div_busy) state_next = ST_FINISH;
            ST_FINISH:       if (!status.out_stall) state_next = ST_IDLE;
            default:         state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd         = '0;
        cmd.div_sel = DSEL_F;
        cmd.mul_sel = MSEL_X;
        cmd.bes_arg = pass_reg;
        unique case (state_reg)
            ST_IDLE:         cmd.accept = s_valid;
            ST_CHECK:        cmd.latch_flags = 1'b1;
            ST_SET_Q:        cmd.set_q = 1'b1;
            ST_SET_D:        cmd.set_d = 1'b1;
            ST_DIVF_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_F;
            end
            ST_DIVF_WAIT:    cmd.sqrt_init = !status.div_busy;
            ST_SQRT:         cmd.sqrt_step = !status.sqrt_done;
            ST_MULX_LO:      cmd.mul_lo = 1'b1;
            ST_MULX_HI:      cmd.mul_hi = 1'b1;
            ST_MULX_WB:      cmd.x_wb = 1'b1;
            ST_BES_INIT:     cmd.bes_init = 1'b1;
            ST_BES_DIV_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_T;
            end
            ST_BES_DIV_WAIT: cmd.div_sel = DSEL_T;
            ST_BES_TT_LO: begin
                cmd.mul_sel = MSEL_TT;
                cmd.mul_lo  = 1'b1;
            end
            ST_BES_TT_HI: begin
                cmd.mul_sel = MSEL_TT;
                cmd.mul_hi  = 1'b1;
            end
            ST_BES_TT_WB:    cmd.t2_wb = 1'b1;
            ST_BES_TM_LO: begin
                cmd.mul_sel = MSEL_TM;
                cmd.mul_lo  = 1'b1;
            end
            ST_BES_TM_HI: begin
                cmd.mul_sel = MSEL_TM;
                cmd.mul_hi  = 1'b1;
            end
            ST_BES_TM_WB:    cmd.term_wb = 1'b1;
            ST_BES_ACC: begin
                cmd.bes_acc   = 1'b1;
                cmd.store_num = status.bes_done && !pass_reg;
                cmd.store_den = status.bes_done && pass_reg;
            end
            ST_DIVC_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_C;
            end
            ST_DIVC_WAIT:    cmd.div_sel = DSEL_C;
            ST_FINISH:       cmd.load_out = !status.out_stall;
            default:         cmd.accept = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

/* tb/sv/kaiser_window_generator_tb.sv */
// Self-checking testbench for the Kaiser window generator: directed and random
// sample indexes across several length/beta settings, checked against a local predictor.
// Depends on kwg_pkg and kaiser_window_generator.
`timescale 1ns / 100ps

module kaiser_window_generator_tb;
    import kwg_pkg::*;

    typedef struct {
        logic [COEF_W-1:0] coef;
        logic              oor;
    } coef_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [IDX_W-1:0]     s_sample_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COEF_W-1:0]    m_coefficient;
    logic                 m_out_of_range;

    // Local copy of the configuration registers
    logic [LEN_W-1:0]     win_len = LEN_RESET;
    logic [BETA_W-1:0]    beta_q412 = BETA_RESET;

    logic [IDX_W-1:0]     index_queue[$];
    coef_result_t         coef_queue[$];
    bit                   no_idle = 1'b0;
    int                   mismatches = 0;
    int                   sent = 0;
    int                   received = 0;
    int                   oor_seen = 0;
    int                   edge_idx[6] = '{0, 31, 32, 63, 64, 4095};

    kaiser_window_generator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_index (s_sample_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_coefficient  (m_coefficient),
        .m_out_of_range (m_out_of_range)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // (a * b) >> 24 built from 32-bit halves, wrapping at 64 bits
    function automatic bit [63:0] q24_mul(bit [63:0] a, bit [63:0] b);
        bit [63:0] ah, al, bh, bl, r;
        ah = a >> 32;
        al = a & 64'hFFFF_FFFF;
        bh = b >> 32;
        bl = b & 64'hFFFF_FFFF;
        r = (ah * bh) << 40;
        r += (ah * bl) << 8;
        r += (al * bh) << 8;
        r += (al * bl) >> 24;
        return r;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] res, b;
        res = 0;
        b = 64'd1 << 32;
        while (b > v && b != 0) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Modified Bessel I0 by power series in Q24.24, stop on a zero term
    function automatic bit [63:0] series_i0(bit [63:0] x);
        bit [63:0] half, sum, term, t;
        half = x >> 1;
        sum = 64'd1 << 24;
        term = 64'd1 << 24;
        for (int k = 1; k < SERIES_TERMS; k++) begin
            t = half / k;
            term = q24_mul(term, q24_mul(t, t));
            sum += term;
            if (term == 0) break;
        end
        return sum;
    endfunction

    function automatic coef_result_t window_coef(logic [IDX_W-1:0] idx);
        coef_result_t r;
        bit [63:0] n, len, m, q, f, x, num, den, c;
        n = idx;
        len = win_len;
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        r.coef = '0;
        r.oor = 1'b0;
        if (len == 0 || n >= len) begin
            r.oor = 1'b1;
        end else if (len == 1) begin
            r.coef = COEF_ONE;
        end else begin
            m = len - 1;
            q = 4 * n * (m - n);
            f = (q << 32) / (m * m);
            x = (64'(beta_q412) * int_sqrt(f)) >> 4;
            num = series_i0(x);
            den = series_i0(64'(beta_q412) << 12);
            c = ((num << 15) + (den >> 1)) / den;
            if (c > 32768) c = 32768;
            r.coef = c[COEF_W-1:0];
        end
        return r;
    endfunction

    // Input driver: advance to the next index once the current one transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                coef_queue.push_back(window_coef(s_sample_index));
                sent++;
            end
            if (!s_valid || s_ready) begin
                if (index_queue.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
                    s_valid <= 1'b1;
                    s_sample_index <= index_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge aclk) begin
        coef_result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                received++;
                if (m_out_of_range) oor_seen++;
                if (coef_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: coef %0d oor %0b",
                                 m_coefficient, m_out_of_range);
                end else begin
                    e = coef_queue.pop_front();
                    if (e.coef !== m_coefficient || e.oor !== m_out_of_range) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: len %0d beta %0d exp coef %0d oor %0b, got %0d %0b",
                                     win_len, beta_q412, e.coef, e.oor,
                                     m_coefficient, m_out_of_range);
                    end
                end
            end
            m_ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_WINDOW_LENGTH) win_len = val[LEN_W-1:0];
        else if (idx == REG_BETA_SHAPE) beta_q412 = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every index has transferred and every result has come back
    task automatic drain();
        while (index_queue.size() != 0 || s_valid || coef_queue.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_window(int len, int beta);
        drain();
        reg_write(REG_WINDOW_LENGTH, CFG_W'(len));
        reg_write(REG_BETA_SHAPE, CFG_W'(beta));
    endtask

    initial begin
        int len, beta, lim;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: ends and middle of the window, just past it, largest index
        foreach (edge_idx[i])
            index_queue.push_back(IDX_W'(edge_idx[i]));
        // Single coefficient
        set_window(1, 20480);
        index_queue.push_back(IDX_W'(0));
        index_queue.push_back(IDX_W'(1));
        // Empty window
        set_window(0, 65535);
        index_queue.push_back(IDX_W'(0));
        index_queue.push_back(IDX_W'(4095));
        // Widest window, largest beta
        set_window(4096, 65535);
        index_queue.push_back(IDX_W'(0));
        index_queue.push_back(IDX_W'(2048));
        index_queue.push_back(IDX_W'(4095));
        // Length above the maximum clamps; writes to unused indexes are dropped
        set_window(8191, 0);
        reg_write(2'd2, 16'hFFFF);
        reg_write(2'd3, 16'h0001);
        index_queue.push_back(IDX_W'(4095));
        index_queue.push_back(IDX_W'(1000));
        set_window(2, 4096);
        index_queue.push_back(IDX_W'(0));
        index_queue.push_back(IDX_W'(1));
        index_queue.push_back(IDX_W'(2));

        // Random phases
        for (int p = 0; p < 16; p++) begin
            case ($urandom_range(5))
                0: len = $urandom_range(3, 2);
                1: len = 4096;
                2: len = $urandom_range(8191, 4097);
                3: len = $urandom_range(1, 0);
                default: len = $urandom_range(4095, 2);
            endcase
            case ($urandom_range(5))
                0: beta = 0;
                1: beta = 65535;
                default: beta = $urandom_range(65535);
            endcase
            set_window(len, beta);
            no_idle = (p == 5);
            lim = (len > 4096) ? 4096 : len;
            repeat (90) begin
                if (lim > 0 && $urandom_range(99) < 75)
                    index_queue.push_back(IDX_W'($urandom_range(lim - 1)));
                else
                    index_queue.push_back(IDX_W'($urandom));
            end
        end
        drain();
        no_idle = 1'b0;

        $display("%0d indexes sent, %0d coefficients checked, %0d out of range",
                 sent, received, oor_seen);
        if (mismatches == 0 && coef_queue.size() == 0)
            $display("kaiser_window_generator_tb: clean");
        else
            $display("kaiser_window_generator_tb: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #120_000_000;
        $display("kaiser_window_generator_tb: errors");
        $finish;
    end

endmodule

/* sim.f */
src/kwg_pkg.sv
src/kwg_divider.sv
src/kwg_datapath.sv
src/kwg_controller.sv
src/kaiser_window_generator.sv
tb/sv/kaiser_window_generator_tb.sv
